// ===== sv/block_variance_ratio_score_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the variance ratio score unit
// Implication and next-cycle checks, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BLOCK_VARIANCE_RATIO_SCORE_UNIT_ASSERT_SVH
`define BLOCK_VARIANCE_RATIO_SCORE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BVRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BVRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BVRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BVRS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/bvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bvrs_pkg
// Widths, datapath operations and status for the variance ratio score unit.
// ----------------------------------------------------------------------------
package bvrs_pkg;

   localparam int MAX_ROW_CLUSTERS = 8;
   localparam int MAX_COL_CLUSTERS = 8;
   localparam int MAX_ELEMENTS     = 65536;

   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int VALUE_W    = 16;
   localparam int LABEL_W    = 3;
   localparam int SCORE_W    = 20;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   localparam int ROW_W      = $clog2(MAX_ROW_CLUSTERS);
   localparam int COL_W      = $clog2(MAX_COL_CLUSTERS);
   localparam int ROW_CNT_W  = ROW_W + 1;
   localparam int COL_CNT_W  = COL_W + 1;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int DEPTH      = MAX_ROW_CLUSTERS * MAX_COL_CLUSTERS;
   localparam int NB_W       = ROW_CNT_W + COL_CNT_W;

   localparam int COUNT_W    = $clog2(MAX_ELEMENTS) + 1;
   localparam int SUM_W      = COUNT_W + VALUE_W;
   localparam int ENTRY_W    = SUM_W + COUNT_W;
   localparam int SQ_W       = COUNT_W + 2 * VALUE_W - 2;

   localparam int MEAN_W     = 24;
   localparam int DIFF_W     = MEAN_W + 1;
   localparam int SQD_W      = 2 * DIFF_W;
   localparam int BNUM_W     = SQD_W + ADDR_W;
   localparam int MSUM_W     = MEAN_W + ADDR_W + 1;
   localparam int GS_W       = MEAN_W + SUM_W - 1;
   localparam int GG_W       = 2 * MEAN_W;
   localparam int NGG_W      = GG_W + COUNT_W;
   localparam int TNUM_W     = 67;
   localparam int BETW_W     = 40;
   localparam int TOT_W      = 40;

   localparam int DIV_W      = 56;
   localparam int DVSR_W     = 40;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_CLUSTERS,
      REG_COL_CLUSTERS
   } csr_reg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE,
      OP_ACC,
      OP_MEAN_ZERO,
      OP_DIV_MEAN,
      OP_MEAN_DIV,
      OP_MSUM,
      OP_SQ,
      OP_BNUM,
      OP_DIV_G,
      OP_G_LOAD,
      OP_DIV_BETWEEN,
      OP_BETWEEN_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_SUM1,
      OP_SUM2,
      OP_DIV_TOTAL,
      OP_TOTAL_LOAD,
      OP_DIV_SCORE,
      OP_SCORE_LOAD,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic last;
      logic cnt_zero;
      logic div_done;
      logic walk_end;
      logic clear_end;
      logic n_zero;
      logic total_zero;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== sv/bvrs_ram.sv =====
// ----------------------------------------------------------------------------
// bvrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bvrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/bvrs_divider.sv =====
// ----------------------------------------------------------------------------
// bvrs_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvrs_divider import bvrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVSR_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     quo_in;
   logic [DVSR_W-1:0]    rem_ff;
   logic [DVSR_W-1:0]    rem_in;
   logic [DVSR_W-1:0]    dvsr_ff;
   logic [DVSR_W:0]      rem_sh;
   logic [DVSR_W:0]      rem_df;
   logic                 fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      rem_df = rem_sh - {1'b0, dvsr_ff};
      fits   = rem_sh >= {1'b0, dvsr_ff};
      rem_in = fits ? rem_df[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
      quo_in = {quo_ff[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvsr_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/bvrs_datapath.sv =====
// ----------------------------------------------------------------------------
// bvrs_datapath
// Block store, grand accumulators, block walk, divider and score arithmetic.
// ----------------------------------------------------------------------------
module bvrs_datapath import bvrs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_op_type                 op,
   output dp_status_type             stat,
   input  logic [CFG_W-1:0]          row_clusters,
   input  logic [CFG_W-1:0]          col_clusters,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [LABEL_W-1:0]        req_row_label,
   input  logic [LABEL_W-1:0]        req_col_label,
   input  logic                      req_last,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [SCORE_W-1:0]        rsp_score,
   output logic                      rsp_zero_variance
);

   logic [ROW_CNT_W-1:0] rc_u;
   logic [COL_CNT_W-1:0] cc_u;
   logic [ROW_W-1:0]     rc_m1;
   logic [COL_W-1:0]     cc_m1;
   logic [ROW_W-1:0]     ri;
   logic [COL_W-1:0]     ci;
   logic [NB_W-1:0]      nb;

   logic signed [VALUE_W-1:0] x_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic                      last_ff;
   logic [ADDR_W-1:0]         clr_addr_ff;
   logic [ROW_W-1:0]          wi_ff;
   logic [COL_W-1:0]          wj_ff;

   logic signed [SUM_W-1:0]   gsum_ff;
   logic [SQ_W-1:0]           gsq_ff;
   logic [COUNT_W-1:0]        ecount_ff;

   logic signed [MEAN_W-1:0]  mean_ff;
   logic signed [MEAN_W-1:0]  g_ff;
   logic signed [MSUM_W-1:0]  msum_ff;
   logic [SQD_W-1:0]          sqd_ff;
   logic [BNUM_W-1:0]         bnum_ff;
   logic [GS_W-1:0]           gs_ff;
   logic [GG_W-1:0]           gg_ff;
   logic [NGG_W-1:0]          ngg_ff;
   logic signed [TNUM_W-1:0]  tnum_ff;
   logic [BETW_W-1:0]         between_ff;
   logic [TOT_W-1:0]          total_ff;
   logic [SCORE_W-1:0]        score_ff;
   logic                      zero_ff;
   logic                      sign_ff;

   logic                      rsp_valid_ff;
   logic [SCORE_W-1:0]        rsp_score_ff;
   logic                      rsp_zero_ff;

   logic                      we;
   logic [ADDR_W-1:0]         waddr;
   logic [ENTRY_W-1:0]        wdata;
   logic [ADDR_W-1:0]         raddr;
   logic [ENTRY_W-1:0]        rdata;
   logic signed [SUM_W-1:0]   rd_sum;
   logic [COUNT_W-1:0]        rd_cnt;
   logic [SUM_W-1:0]          sum_abs;
   logic signed [SUM_W-1:0]   new_sum;
   logic [COUNT_W-1:0]        new_cnt;
   logic                      can_acc;
   logic signed [2*VALUE_W-1:0] x_sq;

   logic                      div_start;
   logic [DIV_W-1:0]          div_a;
   logic [DVSR_W-1:0]         div_b;
   logic                      div_done;
   logic [DIV_W-1:0]          quotient;
   logic [MEAN_W-1:0]         q_mean;
   logic signed [MEAN_W-1:0]  mean_val;

   logic [MSUM_W-1:0]         msum_abs;
   logic signed [DIFF_W-1:0]  d_val;
   logic [DIFF_W-1:0]         d_abs;
   logic [MEAN_W-1:0]         g_abs;
   logic [SUM_W-2:0]          gsum_abs;
   logic signed [TNUM_W-1:0]  t_a;
   logic signed [TNUM_W-1:0]  t_b;
   logic                      walk_end;

   always_comb begin
      if (row_clusters < CFG_W'(2)) begin
         rc_u = ROW_CNT_W'(2);
      end else if (int'(row_clusters) > MAX_ROW_CLUSTERS) begin
         rc_u = ROW_CNT_W'(MAX_ROW_CLUSTERS);
      end else begin
         rc_u = ROW_CNT_W'(row_clusters);
      end
      if (col_clusters < CFG_W'(2)) begin
         cc_u = COL_CNT_W'(2);
      end else if (int'(col_clusters) > MAX_COL_CLUSTERS) begin
         cc_u = COL_CNT_W'(MAX_COL_CLUSTERS);
      end else begin
         cc_u = COL_CNT_W'(col_clusters);
      end
      rc_m1 = ROW_W'(rc_u - 1'b1);
      cc_m1 = COL_W'(cc_u - 1'b1);
      ri    = (int'(req_row_label) > int'(rc_m1)) ? rc_m1 : ROW_W'(req_row_label);
      ci    = (int'(req_col_label) > int'(cc_m1)) ? cc_m1 : COL_W'(req_col_label);
      nb    = NB_W'(rc_u) * NB_W'(cc_u);
   end

   // block store: sum and count per block
   assign rd_sum  = rdata[ENTRY_W-1 -: SUM_W];
   assign rd_cnt  = rdata[COUNT_W-1:0];
   assign sum_abs = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
   assign new_sum = rd_sum + SUM_W'(x_ff);
   assign new_cnt = rd_cnt + 1'b1;
   assign can_acc = ecount_ff < COUNT_W'(MAX_ELEMENTS);
   assign x_sq    = x_ff * x_ff;

   always_comb begin
      raddr = (op == OP_TAKE) ? {ri, ci} : {wi_ff, wj_ff};
      if (op == OP_CLEAR) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = '0;
      end else begin
         we    = (op == OP_ACC) && can_acc;
         waddr = addr_ff;
         wdata = {new_sum, new_cnt};
      end
   end

   bvrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign msum_abs = msum_ff[MSUM_W-1] ? MSUM_W'(-msum_ff) : MSUM_W'(msum_ff);
   assign d_val    = DIFF_W'(mean_ff) - DIFF_W'(g_ff);
   assign d_abs    = d_val[DIFF_W-1] ? DIFF_W'(-d_val) : DIFF_W'(d_val);
   assign g_abs    = g_ff[MEAN_W-1] ? MEAN_W'(-g_ff) : MEAN_W'(g_ff);
   assign gsum_abs = gsum_ff[SUM_W-1] ? (SUM_W-1)'(-gsum_ff) : (SUM_W-1)'(gsum_ff);
   assign t_a      = TNUM_W'({gsq_ff, 16'h0000});
   assign t_b      = TNUM_W'({gs_ff, 9'h000});
   assign walk_end = (wi_ff == rc_m1) && (wj_ff == cc_m1);

   always_comb begin
      div_start = 1'b1;
      div_a     = '0;
      div_b     = '0;
      unique case (op)
         OP_DIV_MEAN: begin
            div_a = DIV_W'({sum_abs, 8'h00});
            div_b = DVSR_W'(rd_cnt);
         end
         OP_DIV_G: begin
            div_a = DIV_W'(msum_abs);
            div_b = DVSR_W'(nb);
         end
         OP_DIV_BETWEEN: begin
            div_a = DIV_W'(bnum_ff[BNUM_W-1:16]);
            div_b = DVSR_W'(nb);
         end
         OP_DIV_TOTAL: begin
            div_a = DIV_W'(tnum_ff[TNUM_W-3:16]);
            div_b = DVSR_W'(ecount_ff);
         end
         OP_DIV_SCORE: begin
            div_a = DIV_W'({between_ff, 16'h0000});
            div_b = DVSR_W'(total_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   bvrs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (quotient)
   );

   assign q_mean   = quotient[MEAN_W-1:0];
   assign mean_val = sign_ff ? MEAN_W'(-q_mean) : MEAN_W'(q_mean);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (op != OP_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (op)
            OP_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               gsum_ff     <= '0;
               gsq_ff      <= '0;
               ecount_ff   <= '0;
            end
            OP_TAKE: begin
               x_ff    <= req_value;
               addr_ff <= {ri, ci};
               last_ff <= req_last;
            end
            OP_ACC: begin
               if (can_acc) begin
                  gsum_ff   <= gsum_ff + SUM_W'(x_ff);
                  gsq_ff    <= gsq_ff + SQ_W'(x_sq);
                  ecount_ff <= ecount_ff + 1'b1;
               end
               wi_ff   <= '0;
               wj_ff   <= '0;
               msum_ff <= '0;
               bnum_ff <= '0;
            end
            OP_MEAN_ZERO: begin
               mean_ff <= '0;
            end
            OP_DIV_MEAN: begin
               sign_ff <= rd_sum[SUM_W-1];
            end
            OP_MEAN_DIV: begin
               mean_ff <= mean_val;
            end
            OP_MSUM, OP_BNUM: begin
               if (op == OP_MSUM) begin
                  msum_ff <= msum_ff + MSUM_W'(mean_ff);
               end else begin
                  bnum_ff <= bnum_ff + BNUM_W'(sqd_ff);
               end
               if (wj_ff == cc_m1) begin
                  wj_ff <= '0;
                  wi_ff <= wi_ff + 1'b1;
               end else begin
                  wj_ff <= wj_ff + 1'b1;
               end
            end
            OP_SQ: begin
               sqd_ff <= d_abs * d_abs;
            end
            OP_DIV_G: begin
               sign_ff <= msum_ff[MSUM_W-1];
            end
            OP_G_LOAD: begin
               g_ff  <= mean_val;
               wi_ff <= '0;
               wj_ff <= '0;
            end
            OP_BETWEEN_LOAD: begin
               between_ff <= quotient[BETW_W-1:0];
               score_ff   <= '0;
               zero_ff    <= 1'b1;
            end
            OP_MUL1: begin
               gs_ff <= g_abs * gsum_abs;
            end
            OP_MUL2: begin
               gg_ff <= g_abs * g_abs;
            end
            OP_MUL3: begin
               ngg_ff <= gg_ff * ecount_ff;
            end
            OP_SUM1: begin
               if (g_ff[MEAN_W-1] == gsum_ff[SUM_W-1]) begin
                  tnum_ff <= t_a - t_b;
               end else begin
                  tnum_ff <= t_a + t_b;
               end
            end
            OP_SUM2: begin
               tnum_ff <= tnum_ff + TNUM_W'(ngg_ff);
            end
            OP_TOTAL_LOAD: begin
               total_ff <= quotient[TOT_W-1:0];
               zero_ff  <= (quotient == '0);
            end
            OP_SCORE_LOAD: begin
               score_ff <= (quotient > DIV_W'(SCORE_MAX)) ? SCORE_MAX
                                                          : quotient[SCORE_W-1:0];
            end
            OP_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_score_ff <= score_ff;
               rsp_zero_ff  <= zero_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stat.last       = last_ff;
      stat.cnt_zero   = (rd_cnt == '0);
      stat.div_done   = div_done;
      stat.walk_end   = walk_end;
      stat.clear_end  = (clr_addr_ff == ADDR_W'(DEPTH - 1));
      stat.n_zero     = (ecount_ff == '0);
      stat.total_zero = zero_ff;
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_score         = rsp_score_ff;
   assign rsp_zero_variance = rsp_zero_ff;

endmodule

// ===== sv/bvrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvrs_ctrl
// Sequencer: clear sweep, accumulate, block walks, divides and result load.
// ----------------------------------------------------------------------------
module bvrs_ctrl import bvrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_op_type     op
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ACC,
      S_W_RD,
      S_W_CHK,
      S_W_DIV,
      S_W_ACC,
      S_W_SQ,
      S_G_DIV,
      S_G_WAIT,
      S_B_DIV,
      S_B_WAIT,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_SUM1,
      S_SUM2,
      S_T_DIV,
      S_T_WAIT,
      S_T_CHK,
      S_S_WAIT,
      S_OUT
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           pass_ff;
   logic           pass_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR;
            if (stat.clear_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_TAKE;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            op       = OP_ACC;
            pass_in  = 1'b0;
            state_in = stat.last ? S_W_RD : S_IDLE;
         end
         S_W_RD: begin
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            if (stat.cnt_zero) begin
               op       = OP_MEAN_ZERO;
               state_in = S_W_ACC;
            end else begin
               op       = OP_DIV_MEAN;
               state_in = S_W_DIV;
            end
         end
         S_W_DIV: begin
            if (stat.div_done) begin
               op       = OP_MEAN_DIV;
               state_in = S_W_ACC;
            end
         end
         S_W_ACC: begin
            if (!pass_ff) begin
               op       = OP_MSUM;
               state_in = stat.walk_end ? S_G_DIV : S_W_RD;
            end else begin
               op       = OP_SQ;
               state_in = S_W_SQ;
            end
         end
         S_W_SQ: begin
            op       = OP_BNUM;
            state_in = stat.walk_end ? S_B_DIV : S_W_RD;
         end
         S_G_DIV: begin
            op       = OP_DIV_G;
            state_in = S_G_WAIT;
         end
         S_G_WAIT: begin
            if (stat.div_done) begin
               op       = OP_G_LOAD;
               pass_in  = 1'b1;
               state_in = S_W_RD;
            end
         end
         S_B_DIV: begin
            op       = OP_DIV_BETWEEN;
            state_in = S_B_WAIT;
         end
         S_B_WAIT: begin
            if (stat.div_done) begin
               op       = OP_BETWEEN_LOAD;
               state_in = stat.n_zero ? S_OUT : S_MUL1;
            end
         end
         S_MUL1: begin
            op       = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            op       = OP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            op       = OP_MUL3;
            state_in = S_SUM1;
         end
         S_SUM1: begin
            op       = OP_SUM1;
            state_in = S_SUM2;
         end
         S_SUM2: begin
            op       = OP_SUM2;
            state_in = S_T_DIV;
         end
         S_T_DIV: begin
            op       = OP_DIV_TOTAL;
            state_in = S_T_WAIT;
         end
         S_T_WAIT: begin
            if (stat.div_done) begin
               op       = OP_TOTAL_LOAD;
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (stat.total_zero) begin
               state_in = S_OUT;
            end else begin
               op       = OP_DIV_SCORE;
               state_in = S_S_WAIT;
            end
         end
         S_S_WAIT: begin
            if (stat.div_done) begin
               op       = OP_SCORE_LOAD;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!stat.out_busy) begin
               op       = OP_OUT;
               state_in = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ===== sv/block_variance_ratio_score_unit.sv =====
// A word without last is taken with a block store read, then written back.
// A last word then starts two walks over the row x column cluster blocks,
// each nonempty mean going through the 56-step divider.
// A new word is not taken until the word before it has been written back.
// Reset: synchronous; a clear sweep of all 64 block store entries follows reset
// and every result, during which no word is taken.
// ----------------------------------------------------------------------------
// block_variance_ratio_score_unit
// Between-block over total variance score of a clustered matrix stream.
// ----------------------------------------------------------------------------
`include "block_variance_ratio_score_unit_assert.svh"
module block_variance_ratio_score_unit import bvrs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [LABEL_W-1:0]        req_row_label,
   input  logic [LABEL_W-1:0]        req_col_label,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SCORE_W-1:0]        rsp_score,
   output logic                      rsp_zero_variance,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   logic [CFG_W-1:0] row_clusters_ff;
   logic [CFG_W-1:0] col_clusters_ff;
   dp_op_type        op;
   dp_status_type    stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_clusters_ff <= CFG_W'(2);
         col_clusters_ff <= CFG_W'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_ROW_CLUSTERS: row_clusters_ff <= csr_wdata;
            REG_COL_CLUSTERS: col_clusters_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bvrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   bvrs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .stat              (stat),
      .row_clusters      (row_clusters_ff),
      .col_clusters      (col_clusters_ff),
      .req_value         (req_value),
      .req_row_label     (req_row_label),
      .req_col_label     (req_col_label),
      .req_last          (req_last),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_score         (rsp_score),
      .rsp_zero_variance (rsp_zero_variance)
   );

   `BVRS_ASSERT_NXT(a_take_holds_off, clock, reset, req_valid && req_ready, !req_ready)
   `BVRS_ASSERT_IMP(a_result_in_clear, clock, reset, $rose(rsp_valid), !req_ready)
   `BVRS_ASSERT_IMP(a_zero_score, clock, reset, rsp_valid && rsp_zero_variance,
      rsp_score == '0)
   `BVRS_ASSERT_NXT(a_csr_row, clock, reset,
      csr_valid && csr_ready && (csr_index == REG_ROW_CLUSTERS),
      row_clusters_ff == $past(csr_wdata))

endmodule
